[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge
`define PFSA_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pfsa assertion failed");

// Same-cycle implication
`define PFSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfsa implication failed");

// Next-cycle implication
`define PFSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfsa next-cycle check failed");

`endif

[hdl/pfsa_pkg.sv]
// ---------------------------------------------------------------------------
// pfsa_pkg
// Constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfsa_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int FRAME_W  = 20;
    localparam int PAGE_W   = 12;
    localparam int PADDR_W  = 32;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'd1;
    localparam logic [FRAME_W-1:0]   START_RESET = 20'd4096;
    localparam logic [FRAME_W-1:0]   END_RESET   = 20'd8192;

    // Request actions
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_SETUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_UNALIGNED = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch request, clear pending result
        logic do_alloc;    // pop: decrement level, start stack read
        logic do_free;     // checked push of the freed frame
        logic setup_init;  // empty stack, load first region frame
        logic setup_push;  // push current region frame
        logic setup_stop;  // record total, set setup status
        logic read_done;   // take popped frame from stack memory
        logic load_out;    // move pending result to output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] act;
        logic       level_zero;
        logic       level_full;
        logic       region_more;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/pfsa_ram.sv]
// ---------------------------------------------------------------------------
// pfsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfsa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/pfsa_ctrl.sv]
// ---------------------------------------------------------------------------
// pfsa_ctrl
// Sequencer for alloc, free and setup requests; drives datapath commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfsa_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pfsa_pkg::dp_stat_t    stat,
    output pfsa_pkg::ctrl_cmd_t        cmd
);

    import pfsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SETUP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.act)
                    ACT_ALLOC:
                    begin
                        cmd.do_alloc = 1'b1;
                        state_next   = stat.level_zero ? S_DONE : S_READ;
                    end
                    ACT_FREE:
                    begin
                        cmd.do_free = 1'b1;
                        state_next  = S_DONE;
                    end
                    ACT_SETUP:
                    begin
                        cmd.setup_init = 1'b1;
                        state_next     = S_SETUP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.read_done = 1'b1;
                state_next    = S_DONE;
            end
            S_SETUP:
            begin
                if (!stat.region_more || stat.level_full)
                begin
                    cmd.setup_stop = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.setup_push = 1'b1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

[hdl/pfsa_datapath.sv]
// ---------------------------------------------------------------------------
// pfsa_datapath
// Frame stack memory, level and total counters, config and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfsa_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pfsa_pkg::ctrl_cmd_t              cmd,
    output pfsa_pkg::dp_stat_t                    stat,
    input  wire logic [1:0]                       action,
    input  wire logic [pfsa_pkg::PADDR_W-1:0]     page_addr,
    input  wire logic                             cfg_we,
    input  wire logic [pfsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pfsa_pkg::CFG_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [pfsa_pkg::PADDR_W-1:0]     frame_addr,
    output logic      [1:0]                       status,
    output logic      [pfsa_pkg::COUNT_W-1:0]     free_count,
    output logic      [pfsa_pkg::COUNT_W-1:0]     total_frames
);

    import pfsa_pkg::*;

    logic [FRAME_W-1:0] start_reg;
    logic [FRAME_W-1:0] end_reg;
    logic [1:0]         act_reg;
    logic [PADDR_W-1:0] faddr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] total_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [PADDR_W-1:0] res_addr_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;

    logic [LEVEL_W-1:0] level_dec;
    logic               level_full;
    logic               unaligned;
    logic               free_ok;
    logic               ram_we;
    logic [FRAME_W-1:0] ram_wdata;
    logic [FRAME_W-1:0] ram_rdata;

    assign level_dec  = level_reg - LEVEL_W'(1);
    assign level_full = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign unaligned  = (faddr_reg[PAGE_W-1:0] != '0);
    assign free_ok    = cmd.do_free && !unaligned && !level_full;

    // Status to controller
    assign stat.act         = act_reg;
    assign stat.level_zero  = (level_reg == '0);
    assign stat.level_full  = level_full;
    assign stat.region_more = (frame_reg < end_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Stack write: freed frame or region frame, always at the current level
    assign ram_we    = free_ok || cmd.setup_push;
    assign ram_wdata = cmd.setup_push ? frame_reg : faddr_reg[PADDR_W-1:PAGE_W];

    pfsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (level_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (level_dec[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Control state: config, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_RESET;
            end_reg       <= END_RESET;
            level_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_START))
            begin
                start_reg <= cfg_data[FRAME_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_END))
            begin
                end_reg <= cfg_data[FRAME_W-1:0];
            end

            if (cmd.setup_init)
            begin
                level_reg <= '0;
            end
            else if (cmd.do_alloc && (level_reg != '0))
            begin
                level_reg <= level_dec;
            end
            else if (free_ok || cmd.setup_push)
            begin
                level_reg <= level_reg + LEVEL_W'(1);
            end

            if (cmd.setup_stop)
            begin
                total_reg <= level_reg;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, pending result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg        <= action;
            faddr_reg      <= page_addr;
            res_addr_reg   <= '0;
            res_status_reg <= ST_OK;
        end

        if (cmd.do_alloc && (level_reg == '0))
        begin
            res_status_reg <= ST_EMPTY;
        end

        if (cmd.do_free)
        begin
            if (unaligned)
            begin
                res_status_reg <= ST_UNALIGNED;
            end
            else if (level_full)
            begin
                res_status_reg <= ST_FULL;
            end
        end

        if (cmd.setup_init)
        begin
            frame_reg <= start_reg;
        end
        else if (cmd.setup_push)
        begin
            frame_reg <= frame_reg + FRAME_W'(1);
        end

        // Setup ends full when frames are left over
        if (cmd.setup_stop && stat.region_more)
        begin
            res_status_reg <= ST_FULL;
        end

        if (cmd.read_done)
        begin
            res_addr_reg <= {ram_rdata, {PAGE_W{1'b0}}};
        end

        if (cmd.load_out)
        begin
            frame_addr   <= res_addr_reg;
            status       <= res_status_reg;
            free_count   <= COUNT_W'(level_reg);
            total_frames <= COUNT_W'(total_reg);
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    `PFSA_ASSERT(a_level_bound, level_reg <= LEVEL_W'(STACK_DEPTH))
    `PFSA_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_reg)
    `PFSA_ASSERT_NEXT(a_level_hold,
        !cmd.do_alloc && !cmd.do_free && !cmd.setup_init && !cmd.setup_push,
        $stable(level_reg))
    `PFSA_ASSERT_IMPL(a_no_write_full, ram_we, !level_full)

endmodule

`default_nettype wire

[hdl/page_frame_stack_allocator.sv]
// ---------------------------------------------------------------------------
// page_frame_stack_allocator
// LIFO allocator of 4 KiB page frames: alloc pops, free pushes, setup
// refills the stack from the configured frame region.
// ---------------------------------------------------------------------------
//  Channel   Signals                                    Handshake
//  request   action, page_addr                          in_valid / in_ready
//  result    frame_addr, status, free_count,            out_valid / out_ready
//            total_frames
//  config    cfg_index, cfg_data                        cfg_we, no wait
//
//  One request at a time. Free and unused actions go from accept through
//  the execute state to the done state; alloc adds a read state for the
//  registered stack read unless the stack is empty; setup pushes one frame
//  a cycle in the setup state, as the stack memory has one write port. The
//  done state loads the result once the output register is free; the next
//  request is taken in idle, also while the previous result waits in the
//  output register. Its result then waits for that slot.
//  Reset clears counters and loads config reset values; stack memory contents are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_frame_stack_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       action,
    input  wire logic [pfsa_pkg::PADDR_W-1:0]     page_addr,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [pfsa_pkg::PADDR_W-1:0]     frame_addr,
    output logic      [1:0]                       status,
    output logic      [pfsa_pkg::COUNT_W-1:0]     free_count,
    output logic      [pfsa_pkg::COUNT_W-1:0]     total_frames,
    input  wire logic                             cfg_we,
    input  wire logic [pfsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pfsa_pkg::CFG_W-1:0]       cfg_data
);

    import pfsa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfsa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .page_addr    (page_addr),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_addr   (frame_addr),
        .status       (status),
        .free_count   (free_count),
        .total_frames (total_frames)
    );

endmodule

`default_nettype wire
